/* src/assert_macros.svh */
// assertion helpers used by the converter core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// generic form: explicit clock and active-low reset
`define SITOA_ASSERT_ON(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// block form: uses the block clock and reset names
`define SITOA_ASSERT(lbl, prop, msg) \
    `SITOA_ASSERT_ON(lbl, i_clk, i_rst_n, prop, msg)

`endif

/* src/sitoa_pkg.sv */
// ----------------------------------------------------------------------------
// sitoa_pkg
// Shared types and constants of the signed integer to decimal text converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sitoa_pkg;

    // default input width
    localparam int VALUE_BITS_DEF = 32;

    // ascii codes
    localparam logic [6:0] CH_ZERO  = 7'd48;
    localparam logic [6:0] CH_MINUS = 7'd45;

    // double dabble correction: digits of five or more get three added
    localparam logic [3:0] DIGIT_ADJ_MIN = 4'd5;
    localparam logic [3:0] DIGIT_ADJ     = 4'd3;

    // control state of the converter
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SKIP,
        ST_SIGN,
        ST_DIGITS
    } t_state;

    // operation applied to every digit cell in a cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_CLEAR,
        CELL_DABBLE,
        CELL_SHIFT
    } t_cell_op;

endpackage

`default_nettype wire

/* src/sitoa_bcd_cell.sv */
// ----------------------------------------------------------------------------
// sitoa_bcd_cell
// One decimal digit of the shift-add-3 chain; also shifts whole digits upward.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sitoa_bcd_cell
    import sitoa_pkg::*;
(
    input  wire logic       i_clk,
    input  wire t_cell_op   i_op,
    input  wire logic       i_carry,
    input  wire logic [3:0] i_digit,
    output logic      [3:0] o_digit,
    output logic            o_carry
);

    logic [3:0] r_digit;
    logic [3:0] n_digit;
    logic [3:0] w_adj;

    // add-3 correction ahead of the shift
    assign w_adj   = (r_digit >= DIGIT_ADJ_MIN) ? (r_digit + DIGIT_ADJ) : r_digit;
    assign o_carry = w_adj[3];
    assign o_digit = r_digit;

    // next digit value
    always_comb begin
        unique case (i_op)
            CELL_HOLD:   n_digit = r_digit;
            CELL_CLEAR:  n_digit = 4'd0;
            CELL_DABBLE: n_digit = {w_adj[2:0], i_carry};
            CELL_SHIFT:  n_digit = i_digit;
            default:     n_digit = r_digit;
        endcase
    end

    // digit register
    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

endmodule

`default_nettype wire

/* src/sitoa_digit_chain.sv */
// ----------------------------------------------------------------------------
// sitoa_digit_chain
// Row of digit cells: binary bits enter at the bottom, digits leave at the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sitoa_digit_chain
    import sitoa_pkg::*;
#(
    parameter int NUM_DIGITS = 10
) (
    input  wire logic       i_clk,
    input  wire t_cell_op   i_op,
    input  wire logic       i_bit,
    output logic      [3:0] o_msd,
    output logic            o_ovf
);

    logic [3:0] w_digits [NUM_DIGITS];
    logic       w_carry  [NUM_DIGITS+1];

    assign w_carry[0] = i_bit;
    assign o_msd      = w_digits[NUM_DIGITS-1];

    // carry out of the top digit, never set while dabbling a valid magnitude
    assign o_ovf      = w_carry[NUM_DIGITS];

    // cell g takes its carry and its shifted digit from cell g-1; cell 0 takes the input bit and a zero digit
    for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_cell
        sitoa_bcd_cell u_cell (
            .i_clk   (i_clk),
            .i_op    (i_op),
            .i_carry (w_carry[g]),
            .i_digit ((g == 0) ? 4'd0 : w_digits[(g == 0) ? 0 : g-1]),
            .o_digit (w_digits[g]),
            .o_carry (w_carry[g+1])
        );
    end

endmodule

`default_nettype wire

/* src/signed_int_to_decimal_ascii_core.sv */
// The value is accepted in idle, passed bit-serially through the digit cell row, and its
// leading zeros are shifted out; then '-' leads negatives and the digits follow, one per
// cycle while the sink does not stall. o_stall holds off a new request until the last
// digit has been loaded into the output register.
// Reset (synchronous, active low) clears the state machine and the output valid flag.
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core
// Signed integer to decimal ascii text, one character per output request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module signed_int_to_decimal_ascii_core
    import sitoa_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic signed [VALUE_BITS-1:0] i_value,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic             [6:0]            o_character,
    output logic                              o_last_char
);

    // digits of 2^(VALUE_BITS-1): floor((VALUE_BITS-1)*log10(2)) + 1
    localparam int NUM_DIGITS = ((VALUE_BITS - 1) * 1233) / 4096 + 1;
    localparam int BIT_CNT_W  = $clog2(VALUE_BITS);
    localparam int LEFT_W     = $clog2(NUM_DIGITS + 1);

    t_state                r_state;
    t_state                n_state;
    logic [BIT_CNT_W-1:0]  r_bit_cnt;
    logic [LEFT_W-1:0]     r_left;
    logic                  r_neg;
    logic [VALUE_BITS-1:0] r_mag;
    logic                  r_out_valid;
    logic [6:0]            r_out_char;
    logic                  r_out_last;

    logic                  w_in_acc;
    logic                  w_out_free;
    logic                  w_out_load;
    logic [6:0]            w_out_char;
    logic                  w_out_last;
    t_cell_op              w_cell_op;
    logic [3:0]            w_msd;
    logic                  w_chain_ovf;
    logic [VALUE_BITS-1:0] w_raw;
    logic [VALUE_BITS-1:0] w_abs;
    logic                  w_msd_zero;
    logic                  w_one_left;
    logic                  w_char_legal;
    logic                  w_minus_out;
    logic                  w_final_load;

    // handshake
    assign w_in_acc    = i_valid && (r_state == ST_IDLE);
    assign o_stall     = (r_state != ST_IDLE);
    assign w_out_free  = !r_out_valid || !i_stall;
    assign o_valid     = r_out_valid;
    assign o_character = r_out_char;
    assign o_last_char = r_out_last;

    // magnitude, one bit of unsigned headroom covers the most negative value
    assign w_raw = i_value;
    assign w_abs = w_raw[VALUE_BITS-1] ? (~w_raw + 1'b1) : w_raw;

    assign w_msd_zero = (w_msd == 4'd0);
    assign w_one_left = (r_left == LEFT_W'(1));

    // digit cell row
    sitoa_digit_chain #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_chain (
        .i_clk (i_clk),
        .i_op  (w_cell_op),
        .i_bit (r_mag[VALUE_BITS-1]),
        .o_msd (w_msd),
        .o_ovf (w_chain_ovf)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) n_state = ST_CONVERT;
            end
            ST_CONVERT: begin
                if (r_bit_cnt == '0) n_state = ST_SKIP;
            end
            ST_SKIP: begin
                if (!w_msd_zero || w_one_left) n_state = r_neg ? ST_SIGN : ST_DIGITS;
            end
            ST_SIGN: begin
                if (w_out_free) n_state = ST_DIGITS;
            end
            ST_DIGITS: begin
                if (w_out_free && w_one_left) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        w_cell_op  = CELL_HOLD;
        w_out_load = 1'b0;
        w_out_char = CH_ZERO + {3'b000, w_msd};
        w_out_last = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) w_cell_op = CELL_CLEAR;
            end
            ST_CONVERT: begin
                w_cell_op = CELL_DABBLE;
            end
            ST_SKIP: begin
                if (w_msd_zero && !w_one_left) w_cell_op = CELL_SHIFT;
            end
            ST_SIGN: begin
                w_out_load = w_out_free;
                w_out_char = CH_MINUS;
            end
            ST_DIGITS: begin
                w_out_load = w_out_free;
                w_out_last = w_one_left;
                if (w_out_free) w_cell_op = CELL_SHIFT;
            end
            default: w_cell_op = CELL_HOLD;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_mag     <= w_abs;
            r_neg     <= w_raw[VALUE_BITS-1];
            r_bit_cnt <= BIT_CNT_W'(VALUE_BITS - 1);
            r_left    <= LEFT_W'(NUM_DIGITS);
        end else begin
            if (r_state == ST_CONVERT) begin
                r_mag     <= {r_mag[VALUE_BITS-2:0], 1'b0};
                r_bit_cnt <= r_bit_cnt - 1'b1;
            end
            if (w_cell_op == CELL_SHIFT) begin
                r_left <= r_left - 1'b1;
            end
        end
        if (w_out_load) begin
            r_out_char <= w_out_char;
            r_out_last <= w_out_last;
        end
    end

    // check terms
    assign w_char_legal = (o_character == CH_MINUS) ||
                          (o_character >= CH_ZERO && o_character <= CH_ZERO + 7'd9);
    assign w_minus_out  = o_valid && (o_character == CH_MINUS);
    assign w_final_load = (r_state == ST_DIGITS) && w_out_load && w_one_left;

    // checks
    `SITOA_ASSERT(a_char_legal, o_valid |-> w_char_legal, "character is neither minus nor digit")
    `SITOA_ASSERT(a_minus_not_last, w_minus_out |-> !o_last_char, "minus sign marked last")
    `SITOA_ASSERT(a_last_ends_run, w_final_load |=> (r_state == ST_IDLE), "busy after last digit")
    `SITOA_ASSERT(a_no_overflow, (w_cell_op == CELL_DABBLE) |-> !w_chain_ovf, "digit row overflow")

endmodule

`default_nettype wire

/* bench/tb_signed_int_to_decimal_ascii_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_signed_int_to_decimal_ascii_core
// Self-checking bench for the signed integer to decimal text converter.
// A short table of directed values, some with their text written out, is
// followed by random values of every digit count and sign. Each accepted
// request queues its expected characters, and every character that leaves
// the block is checked against the oldest one. Both sides idle in bursts.
// ----------------------------------------------------------------------------

module tb_signed_int_to_decimal_ascii_core;
    import sitoa_pkg::*;

    localparam int VB           = VALUE_BITS_DEF;
    localparam int RANDOM_ITEMS = 200;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 64;

    // one character of expected text
    typedef struct packed {
        logic [6:0] ch;
        logic       last;
    } t_text_char;

    // directed table row: text is only used when typed is set
    typedef struct {
        logic signed [VB-1:0] value;
        bit                   typed;
        string                text;
    } t_directed_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic signed [VB-1:0] i_value;
    logic                 o_valid;
    logic                 i_stall;
    logic [6:0]           o_character;
    logic                 o_last_char;

    t_text_char    decimal_text_q[$];
    t_directed_row directed_rows[17];
    int            mismatch_count;
    int            idle_cycles;
    bit            idle_en;

    signed_int_to_decimal_ascii_core #(
        .VALUE_BITS(VB)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_value    (i_value),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_character(o_character),
        .o_last_char(o_last_char)
    );

    // clock
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // queue the decimal text of one value, sign first, digits most significant first
    function automatic void push_decimal_text(input logic signed [VB-1:0] value);
        logic [VB:0] magnitude;
        logic [3:0]  digits[0:20];
        int          n_digits;
        t_text_char  c;
        n_digits = 0;
        magnitude = {1'b0, value};
        if (value[VB-1]) begin
            magnitude = ~{1'b1, value} + 1'b1;
            c.ch = CH_MINUS;
            c.last = 1'b0;
            decimal_text_q.push_back(c);
        end
        do begin
            digits[n_digits] = 4'(magnitude % 10);
            magnitude = magnitude / 10;
            n_digits++;
        end while (magnitude != 0);
        for (int k = n_digits - 1; k >= 0; k--) begin
            c.ch = CH_ZERO + 7'(digits[k]);
            c.last = (k == 0);
            decimal_text_q.push_back(c);
        end
    endfunction

    // queue text written out by hand
    function automatic void push_typed_text(input string text);
        t_text_char c;
        byte        b;
        for (int k = 0; k < text.len(); k++) begin
            b = text[k];
            c.ch = b[6:0];
            c.last = (k == text.len() - 1);
            decimal_text_q.push_back(c);
        end
    endfunction

    // pick a random value, partly spread evenly over digit counts
    function automatic logic signed [VB-1:0] random_value();
        longint mag;
        longint lo;
        longint hi;
        int     kind;
        int     ndig;
        bit     neg;
        kind = $urandom_range(0, 7);
        neg = $urandom_range(0, 1);
        ndig = $urandom_range(1, 10);
        lo = (ndig == 1) ? 0 : 1;
        for (int k = 1; k < ndig; k++) lo = lo * 10;
        hi = (ndig == 1) ? 9 : lo * 10 - 1;
        if (hi > 64'd2147483647) hi = 64'd2147483647;
        case (kind)
            0, 1: begin
                return $urandom();
            end
            2: begin
                // small values
                mag = $urandom_range(0, 20);
            end
            3: begin
                // power-of-ten boundaries
                mag = ($urandom_range(0, 1) && ndig > 1) ? lo - 1 : lo;
                if (ndig == 1) mag = $urandom_range(0, 1) ? 9 : 1;
            end
            4: begin
                // near the extremes of the range
                return neg ? VB'(32'h8000_0000 + $urandom_range(0, 5))
                           : VB'(32'h7FFF_FFFF - $urandom_range(0, 5));
            end
            default: begin
                mag = lo + ({$urandom(), $urandom()} % (hi - lo + 1));
            end
        endcase
        return neg ? -VB'(mag) : VB'(mag);
    endfunction

    // send one request, queueing its expected text at acceptance
    task automatic send_value(input logic signed [VB-1:0] value, input bit typed,
                              input string text);
        int gap;
        if (idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            i_valid <= 1'b0;
            i_value <= $urandom();
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= value;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (typed) push_typed_text(text);
        else push_decimal_text(value);
        @(negedge i_clk);
    endtask

    // sink stall bursts
    initial begin
        int burst;
        burst = 0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!idle_en) begin
                burst = 0;
                i_stall <= 1'b0;
            end else if (burst > 0) begin
                burst--;
                i_stall <= 1'b1;
            end else if ($urandom_range(0, 3) == 0) begin
                burst = $urandom_range(1, 7) - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // check each accepted character against the oldest expected one
    always @(posedge i_clk) begin
        t_text_char want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (decimal_text_q.size() == 0) begin
                report_mismatch($sformatf("unexpected character %0d last=%0b",
                                          o_character, o_last_char));
            end else begin
                want = decimal_text_q.pop_front();
                if (o_character !== want.ch)
                    report_mismatch($sformatf("character got %0d want %0d",
                                              o_character, want.ch));
                if (o_last_char !== want.last)
                    report_mismatch($sformatf("last_char got %0b want %0b on char %0d",
                                              o_last_char, want.last, want.ch));
            end
        end
    end

    // watchdog on cycles with no request moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no request accepted for %0d cycles", STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // main sequence
    initial begin
        mismatch_count = 0;
        idle_cycles = 0;
        idle_en = 1'b1;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_value = '0;

        directed_rows = '{
            '{32'sd0,          1'b1, "0"},
            '{32'sd1,          1'b1, "1"},
            '{-32'sd1,         1'b1, "-1"},
            '{32'h7FFF_FFFF,   1'b1, "2147483647"},
            '{32'h8000_0000,   1'b1, "-2147483648"},
            '{32'sd9,          1'b0, ""},
            '{32'sd10,         1'b0, ""},
            '{32'sd99,         1'b0, ""},
            '{32'sd100,        1'b0, ""},
            '{-32'sd9,         1'b0, ""},
            '{-32'sd10,        1'b0, ""},
            '{32'sd999999999,  1'b0, ""},
            '{32'sd1000000000, 1'b0, ""},
            '{-32'sd1000000000, 1'b0, ""},
            '{32'sd1234567890, 1'b0, ""},
            '{32'h5555_5555,   1'b0, ""},
            '{32'hAAAA_AAAA,   1'b0, ""}
        };

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed table
        foreach (directed_rows[r])
            send_value(directed_rows[r].value, directed_rows[r].typed, directed_rows[r].text);

        // random part: idling on and off in stretches, none at the end
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            idle_en = (n < 50) || (n >= 90 && n < 170);
            send_value(random_value(), 1'b0, "");
        end
        idle_en = 1'b0;
        i_valid <= 1'b0;

        // drain
        while (decimal_text_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
